>>> hdl/adj_pkg.sv
package adj_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_W    = 5;
    localparam int CNT_W     = 6;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(32);
    localparam logic [CNT_W-1:0] NODE_REACH     = CNT_W'(32);

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_SUCC = 2'd2,
        CMD_PRED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_SET,
        OP_CLR,
        OP_ROW,
        OP_COL,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] col;
        logic [CNT_W-1:0]  lim;
    } t_entry;

endpackage

>>> hdl/adj_if.sv
interface adj_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 command;
    logic [adj_pkg::NODE_W-1:0] source_node;
    logic [adj_pkg::NODE_W-1:0] dest_node;

    modport source (output valid, output command, output source_node, output dest_node,
                    input ready);
    modport sink   (input valid, input command, input source_node, input dest_node,
                    output ready);
endinterface

interface adj_res_if;
    logic                       valid;
    logic                       ready;
    logic [adj_pkg::NODE_W-1:0] node_index;
    logic                       found;
    logic                       last;

    modport source (output valid, output node_index, output found, output last,
                    input ready);
    modport sink   (input valid, input node_index, input found, input last,
                    output ready);
endinterface

>>> hdl/adj_front.sv
module adj_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [adj_pkg::CNT_W-1:0] i_cfg_wdata,
    adj_cmd_if.sink                   i_cmd,
    output logic                      o_push,
    output adj_pkg::t_entry           o_entry,
    input  logic                      i_q_ready
);

    logic [adj_pkg::CNT_W-1:0] r_node_count;
    logic [adj_pkg::CNT_W-1:0] act_n;
    logic                      src_ok;
    logic                      dst_ok;
    logic                      keep;
    adj_pkg::t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= adj_pkg::NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // active count clipped to the reach of the node fields
    assign act_n  = (r_node_count > adj_pkg::NODE_REACH) ? adj_pkg::NODE_REACH : r_node_count;
    assign src_ok = {1'b0, i_cmd.source_node} < act_n;
    assign dst_ok = {1'b0, i_cmd.dest_node} < act_n;
    assign cmd    = adj_pkg::t_cmd'(i_cmd.command);

    always_comb begin
        keep          = 1'b1;
        o_entry.row   = i_cmd.source_node;
        o_entry.col   = i_cmd.dest_node;
        o_entry.lim   = act_n;
        o_entry.op    = adj_pkg::OP_EMPTY;
        unique case (cmd)
            adj_pkg::CMD_ADD: begin
                o_entry.op = adj_pkg::OP_SET;
                keep       = src_ok && dst_ok;
            end
            adj_pkg::CMD_DEL: begin
                o_entry.op = adj_pkg::OP_CLR;
                keep       = src_ok && dst_ok;
            end
            adj_pkg::CMD_SUCC: begin
                o_entry.op = src_ok ? adj_pkg::OP_ROW : adj_pkg::OP_EMPTY;
            end
            adj_pkg::CMD_PRED: begin
                o_entry.op = dst_ok ? adj_pkg::OP_COL : adj_pkg::OP_EMPTY;
            end
            default: begin
                o_entry.op = adj_pkg::OP_EMPTY;
            end
        endcase
    end

    // out-of-range writes are taken and dropped
    assign i_cmd.ready = i_q_ready;
    assign o_push      = i_cmd.valid && i_q_ready && keep;

endmodule

>>> hdl/adj_fifo.sv
module adj_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  adj_pkg::t_entry i_entry,
    output logic            o_ready,
    output logic            o_valid,
    output adj_pkg::t_entry o_entry,
    input  logic            i_pop
);

    localparam int CW = $clog2(adj_pkg::QDEPTH + 1);

    adj_pkg::t_entry              r_mem [adj_pkg::QDEPTH];
    logic [adj_pkg::QPTR_W-1:0]   r_wp;
    logic [adj_pkg::QPTR_W-1:0]   r_rp;
    logic [CW-1:0]                r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_ready = r_cnt != CW'(adj_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/adj_back.sv
module adj_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  adj_pkg::t_entry i_entry,
    output logic            o_pop,
    adj_res_if.source       o_res
);

    localparam int MN = adj_pkg::MAX_NODES;
    localparam int NW = adj_pkg::NODE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_ROW,
        S_COL,
        S_EMIT
    } t_state;

    t_state                    r_state;
    adj_pkg::t_op              r_op;
    logic [NW-1:0]             r_row;
    logic [NW-1:0]             r_col;
    logic [adj_pkg::CNT_W-1:0] r_lim;
    logic [NW-1:0]             r_cnt;
    logic [MN-1:0]             r_scan;
    logic                      r_ov;
    logic [NW-1:0]             r_idx;
    logic                      r_found;
    logic                      r_last;

    // matrix rows, with per-row valid flags so reset clears it at once
    logic [MN-1:0]             mem [MN];
    logic [MN-1:0]             r_row_vld;
    logic [MN-1:0]             r_rd_data;
    logic                      r_rd_vld;

    logic                      rd_en;
    logic [NW-1:0]             rd_addr;
    logic                      wr_en;
    logic [MN-1:0]             wr_data;
    logic [MN-1:0]             rd_eff;
    logic [MN-1:0]             lim_mask;
    logic [MN-1:0]             bit_sel;
    logic [MN-1:0]             scan_clr;
    logic                      slot_free;
    logic                      col_done;
    logic                      emit_last;
    logic                      emit;

    assign rd_eff    = r_rd_vld ? r_rd_data : '0;
    assign lim_mask  = ~({MN{1'b1}} << r_lim);
    assign bit_sel   = MN'(1) << r_col;
    assign scan_clr  = r_scan & ~(MN'(1) << r_cnt);
    assign emit_last = scan_clr == '0;
    assign slot_free = !r_ov || o_res.ready;
    assign col_done  = {1'b0, r_cnt} == (r_lim - 1'b1);
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    // a result goes into the output register this cycle
    assign emit      = (r_state == S_EMIT) && slot_free && ((r_scan == '0) || r_scan[r_cnt]);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cnt + 1'b1;
        wr_en   = 1'b0;
        wr_data = (r_op == adj_pkg::OP_SET) ? (rd_eff | bit_sel) : (rd_eff & ~bit_sel);
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    rd_en   = i_entry.op != adj_pkg::OP_EMPTY;
                    rd_addr = (i_entry.op == adj_pkg::OP_COL) ? '0 : i_entry.row;
                end
            end
            S_COL: begin
                rd_en = !col_done;
            end
            S_WR: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_row] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[r_row] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op   <= i_entry.op;
                        r_row  <= i_entry.row;
                        r_col  <= i_entry.col;
                        r_lim  <= i_entry.lim;
                        r_cnt  <= '0;
                        r_scan <= '0;
                        unique case (i_entry.op)
                            adj_pkg::OP_SET,
                            adj_pkg::OP_CLR: r_state <= S_WR;
                            adj_pkg::OP_ROW: r_state <= S_ROW;
                            adj_pkg::OP_COL: r_state <= S_COL;
                            default:         r_state <= S_EMIT;
                        endcase
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_ROW: begin
                    r_scan  <= rd_eff & lim_mask;
                    r_state <= S_EMIT;
                end
                S_COL: begin
                    r_scan[r_cnt] <= rd_eff[r_col];
                    if (col_done) begin
                        r_cnt   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    // an all-clear scan here can only be an empty list
                    if (r_scan == '0) begin
                        if (slot_free) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (r_scan[r_cnt]) begin
                        if (slot_free) begin
                            r_idx   <= r_cnt;
                            r_found <= 1'b1;
                            r_last  <= emit_last;
                            r_scan  <= scan_clr;
                            r_cnt   <= r_cnt + 1'b1;
                            if (emit_last) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.node_index = r_idx;
    assign o_res.found      = r_found;
    assign o_res.last       = r_last;

endmodule

>>> hdl/adjacency_matrix_edge_store.sv
// Directed graph store: a MAX_NODES x MAX_NODES edge bit matrix.
// i_cmd carries requests (add edge, remove edge, list successors, list
// predecessors); o_res carries the node indices a listing finds, ascending,
// with last set on the final one, or a single found=0 result for an empty list.
// i_cfg_we/i_cfg_wdata set node_count; write it only while the block is idle.
// A request is taken into a two-entry queue; the back end then does an edge
// write as a row read and a write back, a successor list as one matrix read
// and a bit walk (one bit position per cycle, holding at a hit while the
// output register is full), and a predecessor list as one matrix row read per
// cycle to gather the column, then the same bit walk. The matrix read is
// registered; each result enters the output register when the walk reaches
// it and that register is free. Reset clears all row valid flags, so the
// matrix reads empty at once, and sets node_count to 32.
// When the receiver stalls, the result register holds and the walk pauses; the
// queue fills and then i_cmd.ready drops.
module adjacency_matrix_edge_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [adj_pkg::CNT_W-1:0] i_cfg_wdata,
    adj_cmd_if.sink                   i_cmd,
    adj_res_if.source                 o_res
);

    logic            push;
    logic            q_ready;
    logic            q_valid;
    logic            pop;
    adj_pkg::t_entry push_entry;
    adj_pkg::t_entry pop_entry;

    // front end: node_count register, range checks, command classification
    adj_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_q_ready   (q_ready)
    );

    // decoupling queue between classification and execution
    adj_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (pop_entry),
        .i_pop   (pop)
    );

    // back end: matrix memory, read-modify-write and scan sequencer
    adj_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (pop_entry),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

>>> tb/sv/adj_result_checker.sv
module adj_result_checker
    import adj_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    adj_cmd_if               i_cmd,
    adj_res_if               i_res,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              found;
        logic              last;
    } t_hit;

    // Shadow graph: bit [r][c] set means edge r -> c
    logic [MAX_NODES-1:0] edge_bits [MAX_NODES];
    logic [CNT_W-1:0]     node_limit;
    t_hit                 listed_nodes [$];
    t_hit                 want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Count in use: register value, clipped to the matrix size and the 5-bit reach
    function automatic int nodes_in_use();
        int n;
        n = int'(node_limit);
        if (n > MAX_NODES)
            n = MAX_NODES;
        if (n > 32)
            n = 32;
        return n;
    endfunction

    // Applies one request to the shadow graph and queues the node list it yields
    task automatic apply_graph_request(input t_cmd op, input logic [NODE_W-1:0] src,
                                       input logic [NODE_W-1:0] dst);
        int   n;
        int   key;
        int   hits;
        logic hit;
        t_hit r;
        n    = nodes_in_use();
        hits = 0;
        case (op)
            CMD_ADD, CMD_DEL: begin
                if (int'(src) < n && int'(dst) < n)
                    edge_bits[src][dst] = (op == CMD_ADD);
            end
            default: begin
                key = (op == CMD_SUCC) ? int'(src) : int'(dst);
                if (key < n) begin
                    for (int i = 0; i < n; i++) begin
                        hit = (op == CMD_SUCC) ? edge_bits[key][i] : edge_bits[i][key];
                        if (hit) begin
                            r.node_index = NODE_W'(i);
                            r.found      = 1'b1;
                            r.last       = 1'b0;
                            listed_nodes = {listed_nodes, r};
                            hits++;
                        end
                    end
                end
                if (hits == 0) begin
                    r.node_index = '0;
                    r.found      = 1'b0;
                    r.last       = 1'b1;
                    listed_nodes = {listed_nodes, r};
                end else begin
                    listed_nodes[listed_nodes.size()-1].last = 1'b1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_NODES; r++)
                edge_bits[r] = '0;
            node_limit = NODE_COUNT_RST;
            listed_nodes.delete();
        end else begin
            if (i_cfg_we)
                node_limit = i_cfg_wdata;
            if (i_res.valid && i_res.ready) begin
                if (listed_nodes.size() == 0) begin
                    $display("%0t: unexpected result: index %0d found %0b last %0b",
                             $time, i_res.node_index, i_res.found, i_res.last);
                    o_mismatches++;
                end else begin
                    want = listed_nodes.pop_front();
                    o_checked++;
                    if (want.node_index !== i_res.node_index || want.found !== i_res.found
                            || want.last !== i_res.last) begin
                        $display("%0t: result mismatch: expected index %0d found %0b last %0b,",
                                 $time, want.node_index, want.found, want.last);
                        $display("    got index %0d found %0b last %0b",
                                 i_res.node_index, i_res.found, i_res.last);
                        o_mismatches++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                apply_graph_request(t_cmd'(i_cmd.command), i_cmd.source_node, i_cmd.dest_node);
        end
        o_pending = listed_nodes.size();
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import adj_pkg::*;

    // Long enough for two queued predecessor scans plus an edge write.
    // Used before node_count writes and at the end, since edge writes return nothing.
    localparam int SETTLE_CYCLES  = 200;
    // Longest legal quiet stretch is the settle wait, or one empty predecessor scan
    // plus a stall run; this is many times that.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 47;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    adj_cmd_if cmd_bus ();
    adj_res_if res_bus ();

    int mismatches;
    int pending;
    int checked;

    // Stimulus knobs, changed per phase
    int send_idle_pct;
    int stall_pct;
    int cur_nodes;
    int sent;
    int quiet_cycles;

    adjacency_matrix_edge_store uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    adj_result_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_cmd        (cmd_bus),
        .i_res        (res_bus),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result receiver: ready redrawn every falling edge, so stalls land on
    // every part of a scan (first hit, middle of a walk, the last flag).
    always @(negedge clk) begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any cycle with no request or result accepted counts as quiet.
    always @(posedge clk) begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // One request. Called and returns at a falling edge; valid is left high
    // so back-to-back requests need no low cycle between them.
    task automatic send_request(input t_cmd op, input int src, input int dst);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.command     <= op;
        cmd_bus.source_node <= NODE_W'(src);
        cmd_bus.dest_node   <= NODE_W'(dst);
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Let every listing come back, then give the back end time to finish
    // edge writes that produce no result.
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called while idle
    task automatic write_node_count(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_nodes = (value > 32) ? 32 : value;
    endtask

    // Mostly in-range nodes so the graph fills and scans return long lists;
    // one in ten lands at or above the count while the count is below 32.
    function automatic int pick_node();
        if (cur_nodes > 0 && (cur_nodes == 32 || $urandom_range(9) != 0))
            return $urandom_range(cur_nodes - 1);
        return $urandom_range(31, cur_nodes);
    endfunction

    task automatic run_random_phase(input int count_value, input int mode);
        int   pick;
        t_cmd op;
        write_node_count(count_value);
        // mode 0: free flow, 1: sender idles, 2: receiver stalls, 3: both
        send_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 33 : 0;
        stall_pct     = (mode == 2) ? 65 : (mode == 3) ? 33 : 0;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = CMD_ADD;
            else if (pick < 55)
                op = CMD_DEL;
            else if (pick < 77)
                op = CMD_SUCC;
            else
                op = CMD_PRED;
            send_request(op, pick_node(), pick_node());
        end
        wait_idle();
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.command     = CMD_ADD;
        cmd_bus.source_node = '0;
        cmd_bus.dest_node   = '0;
        res_bus.ready       = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        cur_nodes           = 32;
        sent                = 0;
        quiet_cycles        = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full count after reset: empty lists first, then corner nodes,
        // self loops, and a remove of an edge that was never added.
        send_request(CMD_SUCC, 0, 0);
        send_request(CMD_PRED, 0, 31);
        send_request(CMD_ADD, 0, 31);
        send_request(CMD_ADD, 31, 0);
        send_request(CMD_ADD, 0, 0);
        send_request(CMD_ADD, 31, 31);
        send_request(CMD_ADD, 5, 31);
        send_request(CMD_ADD, 0, 10);
        send_request(CMD_SUCC, 0, 17);
        send_request(CMD_PRED, 12, 31);
        send_request(CMD_SUCC, 31, 0);
        send_request(CMD_DEL, 0, 31);
        send_request(CMD_DEL, 3, 4);
        send_request(CMD_SUCC, 0, 0);
        wait_idle();

        // Single node: only the self loop on node 0 is visible; writes and
        // queries past it are out of range.
        write_node_count(1);
        send_request(CMD_SUCC, 0, 0);
        send_request(CMD_ADD, 0, 5);
        send_request(CMD_SUCC, 5, 0);
        send_request(CMD_PRED, 0, 0);
        wait_idle();

        // Zero nodes: everything out of range, the remove must not land
        write_node_count(0);
        send_request(CMD_SUCC, 0, 0);
        send_request(CMD_DEL, 0, 0);
        send_request(CMD_PRED, 0, 0);
        wait_idle();

        // Count above the matrix clips to 32; edges hidden above come back
        write_node_count(63);
        send_request(CMD_SUCC, 0, 0);
        send_request(CMD_PRED, 0, 31);
        send_request(CMD_PRED, 0, 0);
        wait_idle();

        // Random phases: each idle mode twice, across the count extremes
        run_random_phase(32, 0);
        run_random_phase(17, 1);
        run_random_phase(2, 2);
        run_random_phase(32, 3);
        run_random_phase(1, 0);
        run_random_phase(9, 1);
        run_random_phase(63, 2);
        run_random_phase(32, 3);

        $display("Covered %0d requests and %0d listed results with node counts 0, 1, 2, 9,",
                 sent, checked);
        $display("17, 32 and 63, under free flow, sender gaps, receiver stalls and both.");
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, pending);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
